### src/softmax_normalizer_core_macros.svh
// assertion macros for the softmax normalizer
`ifndef SOFTMAX_NORMALIZER_CORE_MACROS_SVH
`define SOFTMAX_NORMALIZER_CORE_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define SMX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define SMX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### src/smx_pkg.sv
// shared types, constants and functions for the softmax normalizer
`default_nettype none
package smx_pkg;
    localparam int unsigned IDX_W = 6;
    localparam int unsigned CNT_W = 7;
    localparam int unsigned SUM_W = 23;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    typedef struct packed {
        logic signed [15:0] score;
        logic               final_element;
    } t_in_item;

    typedef struct packed {
        logic [15:0]      probability;
        logic [IDX_W-1:0] position;
        logic             end_of_run;
        logic             overflowed;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_E_RD,
        ST_E_MUL,
        ST_E_TAB,
        ST_E_INT,
        ST_E_WR,
        ST_D_RD,
        ST_D_INIT,
        ST_D_ITER,
        ST_D_OUT
    } t_state;

    typedef struct packed {
        logic clr_vec;
        logic load;
        logic idx_clr;
        logic idx_inc;
        logic e_mul;
        logic e_tab;
        logic e_int;
        logic e_wr;
        logic d_init;
        logic d_iter;
        logic d_out;
    } t_cmd;

    typedef struct packed {
        logic idx_last;
        logic div_done;
    } t_sts;

    function automatic logic [16:0] pow2_frac(input logic [4:0] j);
        logic [16:0] v;
        unique case (j)
            5'd0:  v = 17'd65536;
            5'd1:  v = 17'd62757;
            5'd2:  v = 17'd60097;
            5'd3:  v = 17'd57549;
            5'd4:  v = 17'd55109;
            5'd5:  v = 17'd52773;
            5'd6:  v = 17'd50535;
            5'd7:  v = 17'd48393;
            5'd8:  v = 17'd46341;
            5'd9:  v = 17'd44376;
            5'd10: v = 17'd42495;
            5'd11: v = 17'd40693;
            5'd12: v = 17'd38968;
            5'd13: v = 17'd37316;
            5'd14: v = 17'd35734;
            5'd15: v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

### src/smx_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module smx_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### src/smx_ctrl.sv
// controller state machine sequencing load, exp and divide passes
`default_nettype none
`include "softmax_normalizer_core_macros.svh"
module smx_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_final,
    input  wire smx_pkg::t_sts i_sts,
    output smx_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    import smx_pkg::*;
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            ST_LOAD: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_final) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state = ST_E_RD;
                    end
                end
            end
            ST_E_RD: begin
                n_state = ST_E_MUL;
            end
            ST_E_MUL: begin
                o_cmd.e_mul = 1'b1;
                n_state = ST_E_TAB;
            end
            ST_E_TAB: begin
                o_cmd.e_tab = 1'b1;
                n_state = ST_E_INT;
            end
            ST_E_INT: begin
                o_cmd.e_int = 1'b1;
                n_state = ST_E_WR;
            end
            ST_E_WR: begin
                o_cmd.e_wr = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = ST_D_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = ST_E_RD;
                end
            end
            ST_D_RD: begin
                n_state = ST_D_INIT;
            end
            ST_D_INIT: begin
                o_cmd.d_init = 1'b1;
                n_state = ST_D_ITER;
            end
            ST_D_ITER: begin
                o_cmd.d_iter = 1'b1;
                if (i_sts.div_done) begin
                    n_state = ST_D_OUT;
                end
            end
            ST_D_OUT: begin
                o_cmd.d_out = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.clr_vec = 1'b1;
                    n_state = ST_LOAD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = ST_D_RD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    `SMX_ASSERT_NXT(a_final_leaves_load, i_clk, i_rst_n,
        r_state == ST_LOAD && i_start && i_final, r_state == ST_E_RD)
    `SMX_ASSERT_IMP(a_busy_off_load, i_clk, i_rst_n, r_state != ST_LOAD, o_busy)
    `SMX_ASSERT_NXT(a_out_to_load, i_clk, i_rst_n, o_cmd.clr_vec, r_state == ST_LOAD)
endmodule
`default_nettype wire

### src/smx_datapath.sv
// datapath: score and term stores, exp evaluation, restoring divider
`default_nettype none
`include "softmax_normalizer_core_macros.svh"
module smx_datapath #(
    parameter int unsigned MAX_LEN = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire smx_pkg::t_in_item i_item,
    input  wire smx_pkg::t_cmd     i_cmd,
    output smx_pkg::t_sts          o_sts,
    output logic                   o_valid,
    output smx_pkg::t_out_item     o_item
);
    import smx_pkg::*;
    localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_LEN);

    logic [CNT_W-1:0]  r_count;
    logic signed [15:0] r_max;
    logic [SUM_W-1:0]  r_sum;
    logic              r_drop;
    logic [AW-1:0]     r_idx;
    logic [15:0]       w_score_rd, w_term_rd;
    logic              w_store;
    logic [15:0]       w_term;

    // exp pipeline registers
    logic [31:0]       r_e;
    logic [16:0]       r_t0, r_dt;
    logic [11:0]       r_rem;
    logic [5:0]        r_nsh;

    // divider registers
    logic [39:0]       r_rem_d;
    logic [15:0]       r_quo;
    logic [4:0]        r_bit;
    logic              r_dvalid;

    assign w_store = i_cmd.load && (r_count < CAP);

    smx_ram #(.WIDTH(16), .DEPTH(MAX_LEN)) u_score_ram (
        .i_clk(i_clk), .i_we(w_store), .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_item.score), .i_raddr(r_idx), .o_rdata(w_score_rd));

    smx_ram #(.WIDTH(16), .DEPTH(MAX_LEN)) u_term_ram (
        .i_clk(i_clk), .i_we(i_cmd.e_wr), .i_waddr(r_idx),
        .i_wdata(w_term), .i_raddr(r_idx), .o_rdata(w_term_rd));

    logic signed [15:0] n_max;
    logic [CNT_W-1:0]   n_count;
    always_comb begin
        n_max   = r_max;
        n_count = r_count;
        if (w_store) begin
            n_count = r_count + CNT_W'(1);
            if (i_item.score > r_max) begin
                n_max = i_item.score;
            end
        end
    end

    assign o_sts.idx_last = (CNT_W'(r_idx) + CNT_W'(1) == n_count);
    assign o_sts.div_done = (r_bit == 5'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_vec) begin
            r_count <= '0;
            r_max   <= 16'sh8000;
            r_drop  <= 1'b0;
            r_sum   <= '0;
        end else begin
            r_count <= n_count;
            r_max   <= n_max;
            if (i_cmd.load && !w_store) begin
                r_drop <= 1'b1;
            end
            if (i_cmd.load && i_item.final_element) begin
                r_sum <= '0;
            end else if (i_cmd.e_wr) begin
                r_sum <= r_sum + SUM_W'(w_term);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    // exp of -(max - score)
    logic [16:0] w_diff;
    logic [4:0]  w_j;
    logic [15:0] w_n;
    logic [28:0] w_prod;
    logic [16:0] w_v;
    logic [17:0] w_rnd;
    logic [17:0] w_sh;
    always_comb begin
        w_diff = 17'(r_max) - 17'(signed'(w_score_rd));
        w_j    = {1'b0, r_e[15:12]};
        w_n    = r_e[31:16];
        w_prod = 29'(r_dt) * 29'(r_rem) + 29'd2048;
        w_v    = r_t0 - 17'(w_prod[28:12]);
        w_rnd  = 18'(r_t0) + (r_nsh[4:0] == 5'd0 ? 18'd0 :
                 (18'd1 << (r_nsh[4:0] - 5'd1)));
        w_sh   = w_rnd >> r_nsh[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.e_mul) begin
            r_e <= 32'((34'(w_diff) * 34'(LOG2E_Q16)) >> 8);
        end
        if (i_cmd.e_tab) begin
            r_t0  <= pow2_frac(w_j);
            r_dt  <= pow2_frac(w_j) - pow2_frac(w_j + 5'd1);
            r_rem <= r_e[11:0];
            r_nsh <= (w_n >= 16'd17) ? 6'h20 : {1'b0, w_n[4:0]};
        end
        if (i_cmd.e_int) begin
            r_t0 <= w_v;
        end
    end

    // final term, computed from interpolated value held in r_t0
    always_comb begin
        if (r_nsh[5]) begin
            w_term = 16'd0;
        end else if (w_sh > 18'd65535) begin
            w_term = 16'hFFFF;
        end else begin
            w_term = w_sh[15:0];
        end
    end

    // restoring divider: ((term << 16) + sum/2) / sum, saturated
    logic [39:0] w_div;
    assign w_div = {17'd0, r_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 5'd0;
        end else if (i_cmd.d_init) begin
            r_rem_d <= {8'd0, w_term_rd, 16'd0} + {18'd0, r_sum[SUM_W-1:1]};
            r_quo   <= '0;
            r_bit   <= 5'd17;
            r_dvalid <= (r_sum != '0);
        end else if (i_cmd.d_iter && r_bit != 5'd0) begin
            r_bit <= r_bit - 5'd1;
            if (r_rem_d >= (w_div << (r_bit - 5'd1))) begin
                r_rem_d <= r_rem_d - (w_div << (r_bit - 5'd1));
                if (r_bit == 5'd17) begin
                    r_quo <= 16'hFFFF;
                end else if (r_quo != 16'hFFFF || r_bit == 5'd0) begin
                    r_quo <= r_quo | (16'd1 << (r_bit - 5'd1));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.d_out;
        end
        if (i_cmd.d_out) begin
            o_item.probability <= r_dvalid ? r_quo : 16'd0;
            o_item.position    <= IDX_W'(r_idx);
            o_item.end_of_run  <= o_sts.idx_last;
            o_item.overflowed  <= r_drop;
        end
    end

    `SMX_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CAP)
    `SMX_ASSERT_NXT(a_out_after_cmd, i_clk, i_rst_n, i_cmd.d_out, o_valid)
    `SMX_ASSERT_IMP(a_div_bit_range, i_clk, i_rst_n, 1'b1, r_bit <= 5'd17)
endmodule
`default_nettype wire

### src/softmax_normalizer_core.sv
// the final element starts the exp pass over all N stored elements, then the divide pass
// each result takes a table read, setup, the divider iterations and an output step
// exp steps per element: read, multiply, table, interpolate, write; non-final loads stay idle
// busy stays high from the final transaction until the last result is out
// synchronous active-low reset clears the counters, maximum and state machine
// results cannot be stalled by the receiver
`default_nettype none
module softmax_normalizer_core #(
    parameter int unsigned MAX_LEN = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire smx_pkg::t_in_item   i_item,
    output logic                     o_valid,
    output smx_pkg::t_out_item       o_item
);
    import smx_pkg::*;
    t_cmd w_cmd;
    t_sts w_sts;

    smx_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_final(i_item.final_element), .i_sts(w_sts), .o_cmd(w_cmd), .o_busy(busy));

    smx_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .i_cmd(w_cmd),
        .o_sts(w_sts), .o_valid(o_valid), .o_item(o_item));
endmodule
`default_nettype wire

### verif/tb_softmax_normalizer_core.sv
// testbench for the softmax normalizer core: directed table and random vectors
`timescale 1ns / 100ps
`default_nettype none
module tb_softmax_normalizer_core;
    import smx_pkg::*;

    localparam int unsigned VEC_CAP = 64;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_valid;
    t_out_item o_item;

    softmax_normalizer_core #(.MAX_LEN(VEC_CAP)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [15:0] vec_scores[VEC_CAP];
    int unsigned        vec_len;
    logic signed [15:0] vec_max;
    logic               vec_dropped;
    logic [15:0]        pred_first_prob;
    t_out_item          prob_queue[$];
    int                 fail_count;
    int                 result_count;
    int                 vector_count;
    int                 dropped_vectors;

    localparam logic [16:0] FRAC_TAB[17] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

    function automatic logic [15:0] exp_term(input logic [16:0] mag);
        logic [47:0] e;
        logic [31:0] n;
        logic [15:0] f;
        logic [4:0]  j;
        logic [31:0] v;
        logic [31:0] t;
        e = (48'(mag) * 48'd94548) >> 8;
        n = 32'(e >> 16);
        f = e[15:0];
        j = 5'(f[15:12]);
        if (n >= 17) return 16'd0;
        v = 32'(FRAC_TAB[j]) -
            (((32'(FRAC_TAB[j]) - 32'(FRAC_TAB[j + 1])) * 32'(f[11:0]) + 32'd2048) >> 12);
        if (n == 0) t = v;
        else t = (v + (32'd1 << (n - 1))) >> n;
        return (t > 32'd65535) ? 16'hFFFF : t[15:0];
    endfunction

    task automatic clear_vector();
        vec_len     = 0;
        vec_max     = -16'sd32768;
        vec_dropped = 1'b0;
    endtask

    task automatic predict_softmax(input t_in_item it);
        logic [15:0] terms[VEC_CAP];
        logic [22:0] sum;
        logic [47:0] p;
        t_out_item   r;
        if (vec_len < VEC_CAP) begin
            vec_scores[vec_len] = it.score;
            if (it.score > vec_max) vec_max = it.score;
            vec_len++;
        end else begin
            vec_dropped = 1'b1;
        end
        if (!it.final_element) return;
        sum = '0;
        for (int i = 0; i < vec_len; i++) begin
            terms[i] = exp_term(17'(32'(vec_max) - 32'(vec_scores[i])));
            sum = sum + 23'(terms[i]);
        end
        for (int i = 0; i < vec_len; i++) begin
            p = '0;
            if (sum != 0) begin
                p = ((48'(terms[i]) << 16) + 48'(sum >> 1)) / 48'(sum);
                if (p > 48'd65535) p = 48'd65535;
            end
            r.probability = p[15:0];
            r.position    = IDX_W'(i);
            r.end_of_run  = (i + 1 == vec_len);
            r.overflowed  = vec_dropped;
            if (i == 0) pred_first_prob = r.probability;
            prob_queue.push_back(r);
        end
        vector_count++;
        if (vec_dropped) dropped_vectors++;
        clear_vector();
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid) begin
            result_count++;
            if (prob_queue.size() == 0) begin
                $error("unexpected result position=%0d", o_item.position);
                fail_count++;
            end else begin
                want = prob_queue.pop_front();
                if (o_item.probability !== want.probability) begin
                    $error("probability expected %0d actual %0d", want.probability,
                           o_item.probability);
                    fail_count++;
                end
                if (o_item.position !== want.position) begin
                    $error("position expected %0d actual %0d", want.position,
                           o_item.position);
                    fail_count++;
                end
                if (o_item.end_of_run !== want.end_of_run) begin
                    $error("end_of_run expected %0d actual %0d", want.end_of_run,
                           o_item.end_of_run);
                    fail_count++;
                end
                if (o_item.overflowed !== want.overflowed) begin
                    $error("overflowed expected %0d actual %0d", want.overflowed,
                           o_item.overflowed);
                    fail_count++;
                end
            end
        end
    end

    bit idle_enable;

    // start stays high after the accepting edge; a drain drops it, and the next call may when idling is on
    task automatic send_item(input t_in_item it);
        while (idle_enable && $urandom_range(99) < 13) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_softmax(it);
    endtask

    // directed table: score, final, expected first probability (-1 = predictor only)
    typedef struct {
        logic signed [15:0] score;
        logic               fin;
        int                 first_prob;
    } t_row;

    t_row dir_rows[] = '{
        '{16'sh7FFF, 1'b1, 65535},
        '{-16'sh8000, 1'b1, 65535},
        '{16'sh0000, 1'b1, 65535},
        '{16'sh0100, 1'b0, -1},
        '{16'sh0100, 1'b1, -1},
        '{-16'sh8000, 1'b0, -1},
        '{16'sh7FFF, 1'b1, 0},
        '{16'sh0000, 1'b0, -1},
        '{-16'sh0100, 1'b0, -1},
        '{16'sh0080, 1'b0, -1},
        '{16'sh5555, 1'b0, -1},
        '{-16'sh2AAB, 1'b1, -1},
        '{16'sh0000, 1'b0, -1},
        '{-16'sh0001, 1'b0, -1},
        '{-16'sh0C00, 1'b0, -1},
        '{-16'sh1100, 1'b1, -1}
    };

    task automatic wait_drained();
        int guard;
        guard = 0;
        start <= 1'b0;
        while ((prob_queue.size() != 0 || busy) && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (30) @(posedge i_clk);
    endtask

    task automatic send_vector(input int len, input int spread);
        t_in_item it;
        int base;
        base = $urandom_range(65535);
        for (int k = 0; k < len; k++) begin
            if (spread == 0) it.score = 16'($urandom_range(65535));
            else it.score = 16'(base + $urandom_range(2 * spread) - spread);
            it.final_element = (k == len - 1);
            send_item(it);
        end
    endtask

    initial begin
        t_in_item it;
        int sent;
        int len;
        fail_count      = 0;
        result_count    = 0;
        vector_count    = 0;
        dropped_vectors = 0;
        pred_first_prob = '0;
        idle_enable     = 1'b0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_item          = '0;
        clear_vector();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            it.score         = dir_rows[r].score;
            it.final_element = dir_rows[r].fin;
            send_item(it);
            if (dir_rows[r].first_prob >= 0 && dir_rows[r].fin &&
                pred_first_prob != 16'(dir_rows[r].first_prob)) begin
                $error("probability expected %0d actual %0d (table row %0d)",
                       dir_rows[r].first_prob, pred_first_prob, r);
                fail_count++;
            end
        end
        wait_drained();

        // capacity overflow with a full vector, and a dropped final element
        send_vector(66, 600);
        wait_drained();

        // long stretch without idling, then random idling
        sent = 86;
        while (sent < 320) begin
            idle_enable = (sent > 140);
            case ($urandom_range(9))
                0: len = $urandom_range(VEC_CAP + 3, VEC_CAP + 1);
                1: len = 1;
                2, 3: len = $urandom_range(12, 2);
                default: len = $urandom_range(6, 2);
            endcase
            send_vector(len, ($urandom_range(3) == 0) ? 0 : $urandom_range(3000, 16));
            sent += len;
            if ($urandom_range(4) == 0) wait_drained();
        end
        wait_drained();

        $display("covered %0d vectors, %0d results, %0d vectors with dropped elements",
                 vector_count, result_count, dropped_vectors);
        if (fail_count == 0 && prob_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

### softmax_normalizer_core.f
+incdir+src
src/smx_pkg.sv
src/smx_ram.sv
src/smx_ctrl.sv
src/smx_datapath.sv
src/softmax_normalizer_core.sv
verif/tb_softmax_normalizer_core.sv
